// File: hdl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg: shared types and constants of the grouped convolution block
// widths of the beat fields, command and status codes, control structs
// ----------------------------------------------------------------------------
package gdc_pkg;

  // default sizing of the block
  localparam int MAX_IN_CH_DEF  = 16;
  localparam int MAX_OUT_CH_DEF = 16;
  localparam int MAX_KERN_DEF   = 7;
  localparam int MAX_WIDTH_DEF  = 256;

  // beat field widths
  localparam int CMD_W      = 2;
  localparam int WIDX_W     = 14;
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 4;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 8;
  localparam int SUM_W      = 42;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // register widths
  localparam int GRP_W   = 5;
  localparam int IMH_W   = 13;
  localparam int IMW_W   = 9;
  localparam int KERN_W  = 3;
  localparam int CH_TOT_W = 10;
  localparam int KK_W    = 6;
  localparam int LSZ_W   = 11;
  localparam int TOTAL_W = 21;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 2'd0,
    CMD_PIXEL     = 2'd1,
    CMD_NEW_IMAGE = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_INDEX  = 2'd1,
    STAT_BAD_CONFIG = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUPS = 3'd0,
    REG_ICG    = 3'd1,
    REG_OCG    = 3'd2,
    REG_IMH    = 3'd3,
    REG_IMW    = 3'd4,
    REG_KH     = 3'd5,
    REG_KW     = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_ISSUE,
    S_DRAIN,
    S_UNLOAD
  } state_e;

  // configuration and derived sizes
  typedef struct packed {
    logic [GRP_W-1:0]    groups;
    logic [GRP_W-1:0]    icg;
    logic [GRP_W-1:0]    ocg;
    logic [IMH_W-1:0]    imh;
    logic [IMW_W-1:0]    imw;
    logic [KERN_W-1:0]   kh;
    logic [KERN_W-1:0]   kw;
    logic [CH_TOT_W-1:0] ic;
    logic [CH_TOT_W-1:0] oc;
    logic [LSZ_W-1:0]    lsz;
    logic [TOTAL_W-1:0]  total;
    logic                ok;
    logic                ready;
  } cfg_t;

  // product token travelling down the cell row
  typedef struct packed {
    logic                     vld;
    logic [CHAN_W-1:0]        k;
    logic signed [PROD_W-1:0] prod;
  } tok_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// File: hdl/gdc_if.sv
// ----------------------------------------------------------------------------
// gdc_if: channel interfaces of the grouped convolution block
// input item, result item and configuration write channels
// ----------------------------------------------------------------------------
interface gdc_in_if;
  logic                                valid;
  logic                                ready;
  logic [gdc_pkg::CMD_W-1:0]           cmd;
  logic [gdc_pkg::WIDX_W-1:0]          weight_index;
  logic signed [gdc_pkg::SAMPLE_W-1:0] sample_value;
  modport source (output valid, cmd, weight_index, sample_value, input ready);
  modport sink   (input valid, cmd, weight_index, sample_value, output ready);
endinterface

interface gdc_out_if;
  logic                             valid;
  logic                             ready;
  logic [gdc_pkg::CHAN_W-1:0]       out_channel;
  logic [gdc_pkg::ROW_W-1:0]        out_row;
  logic [gdc_pkg::COL_W-1:0]        out_col;
  logic signed [gdc_pkg::SUM_W-1:0] out_value;
  logic                             last;
  logic [gdc_pkg::STATUS_W-1:0]     status;
  modport source (output valid, out_channel, out_row, out_col, out_value, last, status,
                  input ready);
  modport sink   (input valid, out_channel, out_row, out_col, out_value, last, status,
                  output ready);
endinterface

interface gdc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gdc_pkg::CFG_IDX_W-1:0]   index;
  logic [gdc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/grouped_direct_conv2d_valid.sv
// ----------------------------------------------------------------------------
// grouped_direct_conv2d_valid: grouped 2d convolution, stride 1, no padding
// streams pixel samples into a line store and emits one exact sum per
// output channel each time a full kernel window closes
// ----------------------------------------------------------------------------
// usage:
//   cfg_wr takes register writes (index, data); the user must write only
//   while the block is idle (not enforced). a write restarts the image
//   position and holds in_item.ready low while the derived sizes settle.
//   in_item beats: cmd 0 loads a weight at weight_index, cmd 1 stores a
//   pixel sample (raster order, channel fastest), cmd 2 restarts the image.
//   out_item beats carry one sum per output channel, in channel order, with
//   last on the final one; error beats carry status and last only.
// operation:
//   weight loads, new-image commands and samples that close no window leave
//   the block idle. a sample that closes a window issues oc*icg*kh*kw
//   products (one weight read and one line read each), then drains the cell
//   row and unloads oc sums; no new item is taken until the unload ends.
// reset: registers go to 1, position to zero; weight and line stores are
//   not cleared. the out_item register holds a beat until it is taken; a
//   stalled receiver holds the unload and then the next item.
// ----------------------------------------------------------------------------
module grouped_direct_conv2d_valid #(
  parameter int MAX_IN_CH  = gdc_pkg::MAX_IN_CH_DEF,
  parameter int MAX_OUT_CH = gdc_pkg::MAX_OUT_CH_DEF,
  parameter int MAX_KERN   = gdc_pkg::MAX_KERN_DEF,
  parameter int MAX_WIDTH  = gdc_pkg::MAX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gdc_in_if.sink    in_item,
  gdc_out_if.source out_item,
  gdc_cfg_if.sink   cfg_wr
);

  localparam int NCELL        = (MAX_OUT_CH > 16) ? 16 : MAX_OUT_CH;
  localparam int WEIGHT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERN * MAX_KERN;
  localparam int LINE_DEPTH   = MAX_IN_CH * MAX_KERN * MAX_WIDTH;
  localparam int ROW_SZ       = MAX_WIDTH * MAX_IN_CH;
  localparam int WA_W         = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int LA_W         = $clog2(LINE_DEPTH);
  localparam int CHN_W        = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int DR_LEN       = NCELL + 3;
  localparam int DR_W         = $clog2(DR_LEN + 1);

  localparam int SW = gdc_pkg::SAMPLE_W;
  localparam int KW = gdc_pkg::KERN_W;

  gdc_pkg::cfg_t      cfg;
  logic               pos_clr;
  gdc_pkg::state_e    state_r, state_nxt;
  gdc_pkg::cmd_e      cmd;

  // configuration registers
  gdc_cfg #(
    .MAX_IN_CH (MAX_IN_CH),
    .MAX_OUT_CH(MAX_OUT_CH),
    .MAX_KERN  (MAX_KERN),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .cfg_o    (cfg),
    .pos_clr_o(pos_clr)
  );

  // image position
  logic [gdc_pkg::ROW_W-1:0] row_pos_r;
  logic [gdc_pkg::COL_W-1:0] col_pos_r;
  logic [CHN_W-1:0]          chan_pos_r;
  logic [KW-1:0]             slot_r;

  // window and iteration
  logic [gdc_pkg::ROW_W-1:0]  orow_r;
  logic [gdc_pkg::COL_W-1:0]  ocol_r;
  logic [KW-1:0]              sslot_r, rslot_r;
  logic [gdc_pkg::CHAN_W-1:0] k_r;
  logic [gdc_pkg::GRP_W-1:0]  c_r, kg_r;
  logic [KW-1:0]              r_r, s_r;
  logic [CHN_W-1:0]           base_r;
  logic [WA_W-1:0]            wa_r;
  logic [DR_W-1:0]            drain_r;
  logic [gdc_pkg::CHAN_W-1:0] ucnt_r;

  // memories and product pipeline
  logic signed [SW-1:0] wmem [WEIGHT_DEPTH];
  logic signed [SW-1:0] lmem [LINE_DEPTH];
  logic signed [SW-1:0] w_rd_r, x_rd_r;
  logic                 p1_vld_r, p2_vld_r;
  logic [gdc_pkg::CHAN_W-1:0] p1_k_r, p2_k_r;
  logic signed [gdc_pkg::PROD_W-1:0] prod_r;

  // result register
  logic                             out_valid_r;
  logic [gdc_pkg::CHAN_W-1:0]       out_channel_r;
  logic [gdc_pkg::ROW_W-1:0]        out_row_r;
  logic [gdc_pkg::COL_W-1:0]        out_col_r;
  logic signed [gdc_pkg::SUM_W-1:0] out_value_r;
  logic                             out_last_r;
  gdc_pkg::status_e                 out_status_r, pend_status_r;

  // decode
  logic in_acc, bad_cfg, bad_idx, w_wr, pix, trig, err, out_free;
  logic last_chan, last_s, last_r, last_c, last_k, step_done;
  logic unload_emit, unload_last, load_err;
  gdc_pkg::status_e err_status;
  logic [LA_W-1:0]  la_wr, la_rd;
  logic [CHN_W-1:0] rd_ch;
  logic [gdc_pkg::COL_W-1:0] rd_col;
  gdc_pkg::cell_ctl_t cell_ctl;
  gdc_pkg::tok_t      tok_head;
  gdc_pkg::tok_t      tok [NCELL];
  logic signed [gdc_pkg::SUM_W-1:0] sums [NCELL+1];

  assign cmd      = gdc_pkg::cmd_e'(in_item.cmd);
  assign in_acc   = in_item.valid && in_item.ready;
  assign out_free = !out_valid_r || out_item.ready;

  always_comb begin
    bad_cfg    = ((cmd == gdc_pkg::CMD_LOAD) || (cmd == gdc_pkg::CMD_PIXEL)) && !cfg.ok;
    bad_idx    = (cmd == gdc_pkg::CMD_LOAD) && cfg.ok &&
                 ((gdc_pkg::TOTAL_W'(in_item.weight_index) >= cfg.total) ||
                  (32'(in_item.weight_index) >= WEIGHT_DEPTH));
    err        = in_acc && (bad_cfg || bad_idx);
    err_status = bad_cfg ? gdc_pkg::STAT_BAD_CONFIG : gdc_pkg::STAT_BAD_INDEX;
    w_wr       = in_acc && (cmd == gdc_pkg::CMD_LOAD) && cfg.ok && !bad_idx;
    pix        = in_acc && (cmd == gdc_pkg::CMD_PIXEL) && cfg.ok;
    last_chan  = (gdc_pkg::CH_TOT_W'(chan_pos_r) + 1'b1) >= cfg.ic;
    trig       = pix && ((gdc_pkg::CH_TOT_W'(chan_pos_r) + 1'b1) == cfg.ic) &&
                 ((gdc_pkg::IMH_W'(row_pos_r) + 1'b1) >= gdc_pkg::IMH_W'(cfg.kh)) &&
                 ((gdc_pkg::IMW_W'(col_pos_r) + 1'b1) >= gdc_pkg::IMW_W'(cfg.kw));
  end

  // line store addresses
  always_comb begin
    rd_col = ocol_r + gdc_pkg::COL_W'(s_r);
    rd_ch  = base_r + CHN_W'(c_r);
    la_wr  = LA_W'(slot_r) * LA_W'(ROW_SZ) + LA_W'(col_pos_r) * LA_W'(MAX_IN_CH) +
             LA_W'(chan_pos_r);
    la_rd  = LA_W'(rslot_r) * LA_W'(ROW_SZ) + LA_W'(rd_col) * LA_W'(MAX_IN_CH) +
             LA_W'(rd_ch);
  end

  // iteration ends
  always_comb begin
    last_s    = (4'(s_r) + 4'd1) == 4'(cfg.kw);
    last_r    = (4'(r_r) + 4'd1) == 4'(cfg.kh);
    last_c    = (gdc_pkg::GRP_W'(c_r) + 1'b1) == cfg.icg;
    last_k    = (gdc_pkg::CH_TOT_W'(k_r) + 1'b1) == cfg.oc;
    step_done = last_s && last_r && last_c && last_k;
    unload_last = (gdc_pkg::CH_TOT_W'(ucnt_r) + 1'b1) == cfg.oc;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshake
  always_comb begin
    state_nxt     = state_r;
    in_item.ready = 1'b0;
    unload_emit   = 1'b0;
    load_err      = 1'b0;
    case (state_r)
      gdc_pkg::S_IDLE: begin
        in_item.ready = cfg.ready;
        if (err) begin
          if (out_free) begin
            load_err = 1'b1;
          end else begin
            state_nxt = gdc_pkg::S_ERR;
          end
        end else if (trig) begin
          state_nxt = gdc_pkg::S_ISSUE;
        end
      end
      gdc_pkg::S_ERR: begin
        if (out_free) begin
          load_err  = 1'b1;
          state_nxt = gdc_pkg::S_IDLE;
        end
      end
      gdc_pkg::S_ISSUE: begin
        if (step_done) begin
          state_nxt = gdc_pkg::S_DRAIN;
        end
      end
      gdc_pkg::S_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt = gdc_pkg::S_UNLOAD;
        end
      end
      gdc_pkg::S_UNLOAD: begin
        if (out_free) begin
          unload_emit = 1'b1;
          if (unload_last) begin
            state_nxt = gdc_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = gdc_pkg::S_IDLE;
    endcase
  end

  // position update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r  <= '0;
      col_pos_r  <= '0;
      chan_pos_r <= '0;
      slot_r     <= '0;
    end else if (pos_clr || (in_acc && (cmd == gdc_pkg::CMD_NEW_IMAGE))) begin
      row_pos_r  <= '0;
      col_pos_r  <= '0;
      chan_pos_r <= '0;
      slot_r     <= '0;
    end else if (pix) begin
      if (last_chan) begin
        chan_pos_r <= '0;
        if ((gdc_pkg::IMW_W'(col_pos_r) + 1'b1) >= cfg.imw) begin
          col_pos_r <= '0;
          if ((gdc_pkg::IMH_W'(row_pos_r) + 1'b1) >= cfg.imh) begin
            row_pos_r <= '0;
            slot_r    <= '0;
          end else begin
            row_pos_r <= row_pos_r + 1'b1;
            slot_r    <= ((slot_r + 1'b1) == cfg.kh) ? '0 : slot_r + 1'b1;
          end
        end else begin
          col_pos_r <= col_pos_r + 1'b1;
        end
      end else begin
        chan_pos_r <= chan_pos_r + 1'b1;
      end
    end
  end

  // window iteration counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      c_r     <= '0;
      r_r     <= '0;
      s_r     <= '0;
      kg_r    <= '0;
      base_r  <= '0;
      wa_r    <= '0;
      rslot_r <= '0;
      sslot_r <= '0;
      drain_r <= '0;
      ucnt_r  <= '0;
    end else begin
      if (trig) begin
        k_r     <= '0;
        c_r     <= '0;
        r_r     <= '0;
        s_r     <= '0;
        kg_r    <= '0;
        base_r  <= '0;
        wa_r    <= '0;
        ucnt_r  <= '0;
        sslot_r <= ((slot_r + 1'b1) == cfg.kh) ? '0 : slot_r + 1'b1;
        rslot_r <= ((slot_r + 1'b1) == cfg.kh) ? '0 : slot_r + 1'b1;
      end else if (state_r == gdc_pkg::S_ISSUE) begin
        wa_r    <= wa_r + 1'b1;
        drain_r <= DR_W'(DR_LEN);
        if (!last_s) begin
          s_r <= s_r + 1'b1;
        end else begin
          s_r <= '0;
          if (!last_r) begin
            r_r     <= r_r + 1'b1;
            rslot_r <= ((rslot_r + 1'b1) == cfg.kh) ? '0 : rslot_r + 1'b1;
          end else begin
            r_r     <= '0;
            rslot_r <= sslot_r;
            if (!last_c) begin
              c_r <= c_r + 1'b1;
            end else begin
              c_r <= '0;
              k_r <= k_r + 1'b1;
              if ((kg_r + 1'b1) == cfg.ocg) begin
                kg_r   <= '0;
                base_r <= base_r + CHN_W'(cfg.icg);
              end else begin
                kg_r <= kg_r + 1'b1;
              end
            end
          end
        end
      end else if (state_r == gdc_pkg::S_DRAIN) begin
        drain_r <= drain_r - 1'b1;
      end else if (unload_emit) begin
        ucnt_r <= ucnt_r + 1'b1;
      end
    end
  end

  // window origin
  always_ff @(posedge clk) begin
    if (trig) begin
      orow_r <= row_pos_r + 1'b1 - gdc_pkg::ROW_W'(cfg.kh);
      ocol_r <= col_pos_r + 1'b1 - gdc_pkg::COL_W'(cfg.kw);
    end
  end

  // weight store
  always_ff @(posedge clk) begin
    if (w_wr) begin
      wmem[WA_W'(in_item.weight_index)] <= in_item.sample_value;
    end
    w_rd_r <= wmem[wa_r];
  end

  // line store
  always_ff @(posedge clk) begin
    if (pix) begin
      lmem[la_wr] <= in_item.sample_value;
    end
    x_rd_r <= lmem[la_rd];
  end

  // read and multiply stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= (state_r == gdc_pkg::S_ISSUE);
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_k_r <= k_r;
    p2_k_r <= p1_k_r;
    prod_r <= w_rd_r * x_rd_r;
  end

  // cell row
  always_comb begin
    tok_head.vld   = p2_vld_r;
    tok_head.k     = p2_k_r;
    tok_head.prod  = prod_r;
    cell_ctl.clear = trig;
    cell_ctl.shift = unload_emit;
  end

  assign tok[0]       = tok_head;
  assign sums[NCELL]  = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i < NCELL - 1) begin : g_mid
      gdc_cell #(.IDX(gdc_pkg::CHAN_W'(i))) u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (cell_ctl),
        .tok_i(tok[i]),
        .tok_o(tok[i+1]),
        .sum_i(sums[i+1]),
        .sum_o(sums[i])
      );
    end else begin : g_end
      gdc_cell #(.IDX(gdc_pkg::CHAN_W'(i))) u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (cell_ctl),
        .tok_i(tok[i]),
        .tok_o(),
        .sum_i(sums[i+1]),
        .sum_o(sums[i])
      );
    end
  end

  // pending error status
  always_ff @(posedge clk) begin
    if (err) begin
      pend_status_r <= err_status;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_err || unload_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      out_channel_r <= '0;
      out_row_r     <= '0;
      out_col_r     <= '0;
      out_value_r   <= '0;
      out_last_r    <= 1'b1;
      out_status_r  <= (state_r == gdc_pkg::S_ERR) ? pend_status_r : err_status;
    end else if (unload_emit) begin
      out_channel_r <= ucnt_r;
      out_row_r     <= orow_r;
      out_col_r     <= ocol_r;
      out_value_r   <= sums[0];
      out_last_r    <= unload_last;
      out_status_r  <= gdc_pkg::STAT_OK;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.out_channel = out_channel_r;
  assign out_item.out_row     = out_row_r;
  assign out_item.out_col     = out_col_r;
  assign out_item.out_value   = out_value_r;
  assign out_item.last        = out_last_r;
  assign out_item.status      = out_status_r;

`ifndef SYNTH
  // final sum of a window goes out flagged last
  a_unload_last: assert property (@(posedge clk) disable iff (!rst_n)
    (unload_emit && unload_last) |=> (out_item.valid && out_item.last))
    else $error("last sum of a window not flagged last");

  // no product may still be in flight once unload starts
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdc_pkg::S_UNLOAD) |-> (!p1_vld_r && !p2_vld_r))
    else $error("products still in flight during unload");

  // weight reads stay below the configured weight count
  a_wa_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdc_pkg::S_ISSUE) |-> (gdc_pkg::TOTAL_W'(wa_r) < cfg.total))
    else $error("weight read beyond configured weight count");
`endif

endmodule

// File: hdl/gdc_cfg.sv
// ----------------------------------------------------------------------------
// gdc_cfg: configuration registers
// holds the seven registers, derives channel totals and window sizes in
// registered steps, checks the configuration and flags when it has settled
// ----------------------------------------------------------------------------
module gdc_cfg #(
  parameter int MAX_IN_CH  = gdc_pkg::MAX_IN_CH_DEF,
  parameter int MAX_OUT_CH = gdc_pkg::MAX_OUT_CH_DEF,
  parameter int MAX_KERN   = gdc_pkg::MAX_KERN_DEF,
  parameter int MAX_WIDTH  = gdc_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  gdc_cfg_if.sink         cfg_wr,
  output gdc_pkg::cfg_t   cfg_o,
  output logic            pos_clr_o
);

  logic                             wr;
  logic                             hit;
  logic [gdc_pkg::GRP_W-1:0]        groups_r, icg_r, ocg_r;
  logic [gdc_pkg::IMH_W-1:0]        imh_r;
  logic [gdc_pkg::IMW_W-1:0]        imw_r;
  logic [gdc_pkg::KERN_W-1:0]       kh_r, kw_r;
  logic [gdc_pkg::CH_TOT_W-1:0]     ic_r, oc_r;
  logic [gdc_pkg::KK_W-1:0]         khkw_r;
  logic [gdc_pkg::LSZ_W-1:0]        lsz_r;
  logic [gdc_pkg::TOTAL_W-1:0]      total_r;
  logic                             ok_r;
  logic [1:0]                       settle_r;

  assign cfg_wr.ready = 1'b1;
  assign wr = cfg_wr.valid && cfg_wr.ready;

  // index decode
  always_comb begin
    case (gdc_pkg::cfg_reg_e'(cfg_wr.index))
      gdc_pkg::REG_GROUPS, gdc_pkg::REG_ICG, gdc_pkg::REG_OCG, gdc_pkg::REG_IMH,
      gdc_pkg::REG_IMW, gdc_pkg::REG_KH, gdc_pkg::REG_KW: hit = 1'b1;
      default: hit = 1'b0;
    endcase
  end

  assign pos_clr_o = wr && hit;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      groups_r <= gdc_pkg::GRP_W'(1);
      icg_r    <= gdc_pkg::GRP_W'(1);
      ocg_r    <= gdc_pkg::GRP_W'(1);
      imh_r    <= gdc_pkg::IMH_W'(1);
      imw_r    <= gdc_pkg::IMW_W'(1);
      kh_r     <= gdc_pkg::KERN_W'(1);
      kw_r     <= gdc_pkg::KERN_W'(1);
    end else if (wr) begin
      case (gdc_pkg::cfg_reg_e'(cfg_wr.index))
        gdc_pkg::REG_GROUPS: groups_r <= cfg_wr.data[gdc_pkg::GRP_W-1:0];
        gdc_pkg::REG_ICG:    icg_r    <= cfg_wr.data[gdc_pkg::GRP_W-1:0];
        gdc_pkg::REG_OCG:    ocg_r    <= cfg_wr.data[gdc_pkg::GRP_W-1:0];
        gdc_pkg::REG_IMH:    imh_r    <= cfg_wr.data[gdc_pkg::IMH_W-1:0];
        gdc_pkg::REG_IMW:    imw_r    <= cfg_wr.data[gdc_pkg::IMW_W-1:0];
        gdc_pkg::REG_KH:     kh_r     <= cfg_wr.data[gdc_pkg::KERN_W-1:0];
        gdc_pkg::REG_KW:     kw_r     <= cfg_wr.data[gdc_pkg::KERN_W-1:0];
        default: ;
      endcase
    end
  end

  // derived sizes, one multiply per step
  always_ff @(posedge clk) begin
    ic_r    <= gdc_pkg::CH_TOT_W'(groups_r) * gdc_pkg::CH_TOT_W'(icg_r);
    oc_r    <= gdc_pkg::CH_TOT_W'(groups_r) * gdc_pkg::CH_TOT_W'(ocg_r);
    khkw_r  <= gdc_pkg::KK_W'(kh_r) * gdc_pkg::KK_W'(kw_r);
    lsz_r   <= gdc_pkg::LSZ_W'(icg_r) * gdc_pkg::LSZ_W'(khkw_r);
    total_r <= gdc_pkg::TOTAL_W'(oc_r) * gdc_pkg::TOTAL_W'(lsz_r);
    ok_r    <= (groups_r != '0) && (icg_r != '0) && (ocg_r != '0) &&
               (imh_r != '0) && (imw_r != '0) && (kh_r != '0) && (kw_r != '0) &&
               (32'(ic_r) <= MAX_IN_CH) && (32'(oc_r) <= MAX_OUT_CH) &&
               (32'(oc_r) <= 16) &&
               (32'(kh_r) <= MAX_KERN) && (32'(kw_r) <= MAX_KERN) &&
               (32'(imw_r) <= MAX_WIDTH) && (32'(imw_r) <= 256) &&
               (32'(imh_r) <= 4096) &&
               (gdc_pkg::IMH_W'(kh_r) <= imh_r) && (gdc_pkg::IMW_W'(kw_r) <= imw_r);
  end

  // hold off items until the derived values are current
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 2'd3;
    end else if (wr) begin
      settle_r <= 2'd3;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  always_comb begin
    cfg_o        = '0;
    cfg_o.groups = groups_r;
    cfg_o.icg    = icg_r;
    cfg_o.ocg    = ocg_r;
    cfg_o.imh    = imh_r;
    cfg_o.imw    = imw_r;
    cfg_o.kh     = kh_r;
    cfg_o.kw     = kw_r;
    cfg_o.ic     = ic_r;
    cfg_o.oc     = oc_r;
    cfg_o.lsz    = lsz_r;
    cfg_o.total  = total_r;
    cfg_o.ok     = ok_r;
    cfg_o.ready  = (settle_r == 2'd0);
  end

endmodule

// File: hdl/gdc_cell.sv
// ----------------------------------------------------------------------------
// gdc_cell: one accumulator cell of the row
// adds products tagged with its own output channel, passes the token on to
// its right neighbor each cycle and shifts its sum left during unload
// ----------------------------------------------------------------------------
module gdc_cell #(
  parameter logic [gdc_pkg::CHAN_W-1:0] IDX = '0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gdc_pkg::cell_ctl_t               ctl,
  input  gdc_pkg::tok_t                    tok_i,
  output gdc_pkg::tok_t                    tok_o,
  input  logic signed [gdc_pkg::SUM_W-1:0] sum_i,
  output logic signed [gdc_pkg::SUM_W-1:0] sum_o
);

  gdc_pkg::tok_t                    tok_r;
  logic signed [gdc_pkg::SUM_W-1:0] acc_r;

  // token hand-off to the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_i;
    end
  end

  // accumulate own channel, clear at start, shift during unload
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.shift) begin
      acc_r <= sum_i;
    end else if (tok_i.vld && (tok_i.k == IDX)) begin
      acc_r <= acc_r + gdc_pkg::SUM_W'(tok_i.prod);
    end
  end

  assign tok_o = tok_r;
  assign sum_o = acc_r;

endmodule
